[rtl/nnrp_pkg.sv]
// Shared types and constants for the name/number record parser.
// No dependencies; every other file refers to this package by scoped names.
package nnrp_pkg;

  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 6;
  localparam int LEN_W   = 7;
  localparam int POP_W   = 64;

  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

  // Where in the record the parser stands.
  typedef enum logic [1:0] {
    PH_NAME,
    PH_NUM,
    PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NO_COMMA,
    ST_NAME_LONG,
    ST_NAME_EMPTY,
    ST_DIGITS_LONG,
    ST_NO_DIGITS,
    ST_NON_DIGIT,
    ST_ZERO
  } status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              line_end;
  } item_t;

endpackage

[rtl/nnrp_if.sv]
// Valid/ready channel interfaces for the record parser input bytes and results.
// Depends on nnrp_pkg for widths and the status type.
interface nnrp_in_if;
  logic                          valid;
  logic                          ready;
  logic [nnrp_pkg::CHAR_W-1:0]   char_code;
  logic                          line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface nnrp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_name_byte;
  logic [nnrp_pkg::CHAR_W-1:0]   name_byte;
  logic [nnrp_pkg::INDEX_W-1:0]  name_index;
  logic                          record_done;
  nnrp_pkg::status_t             status;
  logic [nnrp_pkg::POP_W-1:0]    population;
  logic [nnrp_pkg::LEN_W-1:0]    name_length;

  modport source (output valid, output is_name_byte, output name_byte, output name_index,
                  output record_done, output status, output population,
                  output name_length, input ready);
  modport sink   (input valid, input is_name_byte, input name_byte, input name_index,
                  input record_done, input status, input population,
                  input name_length, output ready);
endinterface

[rtl/name_number_record_parser.sv]
// Path: a byte transaction loads the input register; the result that the byte produces then
// loads the result register, which offers it downstream (input register, result register).
// Throughput: one byte per cycle; a new byte is taken while a result waits downstream unless
// the held byte also produces a result. The pace is set by the combinational decode and the
// times-ten accumulate between the registers. Bytes that produce no result (comma, long-name
// overflow, number-field bytes, drained bytes) still pass through the input register.
// Reset (rst, synchronous, active high) empties both registers and returns to the name field.
// Top level of the name/number record parser; depends on nnrp_pkg, nnrp_if, nnrp_in_stage, nnrp_core.
module name_number_record_parser #(
  parameter int NAME_LIMIT  = 64,
  parameter int DIGIT_LIMIT = 64
) (
  input logic        clk,
  input logic        rst,
  nnrp_in_if.sink    rec_in,
  nnrp_out_if.source rec_out
);

  // The input register hands one captured byte to the core, which consumes it
  // once the result register can accept whatever the byte produces.
  logic            item_valid;
  logic            item_take;
  nnrp_pkg::item_t item;

  nnrp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .rec_in     (rec_in),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // The core keeps the record state, emits name bytes with their index, and
  // closes each record with a status and the saturated 64-bit value.
  nnrp_core #(
    .NAME_LIMIT  (NAME_LIMIT),
    .DIGIT_LIMIT (DIGIT_LIMIT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .rec_out    (rec_out)
  );

endmodule

[rtl/nnrp_in_stage.sv]
// Input register of the record parser: captures one byte transaction.
// Depends on nnrp_pkg and nnrp_in_if.
module nnrp_in_stage (
  input  logic            clk,
  input  logic            rst,
  nnrp_in_if.sink         rec_in,
  output logic            item_valid,
  output nnrp_pkg::item_t item,
  input  logic            item_take
);

  logic held;

  // The register refills in the same cycle the core consumes its content.
  assign rec_in.ready = !held || item_take;
  assign item_valid   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (rec_in.ready) begin
      held <= rec_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_in.valid && rec_in.ready) begin
      item.char_code <= rec_in.char_code;
      item.line_end  <= rec_in.line_end;
    end
  end

endmodule

[rtl/nnrp_core.sv]
// Parsing core: record state, per-byte decode and accumulate, and result register.
// Depends on nnrp_pkg and nnrp_out_if.
module nnrp_core #(
  parameter int NAME_LIMIT  = 64,
  parameter int DIGIT_LIMIT = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  nnrp_pkg::item_t item,
  output logic            item_take,
  nnrp_out_if.source      rec_out
);

  localparam int NCW = $clog2(NAME_LIMIT + 1);
  localparam int DCW = $clog2(DIGIT_LIMIT + 2);
  localparam int PW  = nnrp_pkg::POP_W;
  localparam int SW  = PW + 4;

  // Record state.
  nnrp_pkg::phase_t phase, phase_next;
  logic [NCW-1:0]   name_count, name_count_next;
  logic [DCW-1:0]   digit_count, digit_count_next;
  logic [PW-1:0]    value_acc, value_acc_next;
  logic             overflowed, overflowed_next;
  logic             bad_digit_seen, bad_digit_seen_next;

  // Result computed for the current byte.
  logic                            res_valid;
  logic                            res_name;
  logic                            res_done;
  nnrp_pkg::status_t               res_status;
  logic [PW-1:0]                   res_pop;
  nnrp_pkg::status_t               fin_status;
  logic [PW-1:0]                   fin_pop;

  logic [NCW+6:0] count_ext;
  logic [SW-1:0]  acc_sum;
  logic           is_digit;
  logic           out_free;
  logic           fire;

  assign count_ext = (NCW + 7)'(name_count);
  assign is_digit  = (item.char_code >= nnrp_pkg::CH_ZERO) &&
                     (item.char_code <= nnrp_pkg::CH_NINE);
  // value * 10 + digit; the top four bits flag saturation.
  assign acc_sum = {1'b0, value_acc, 3'b000} + {3'b000, value_acc, 1'b0} +
                   SW'(item.char_code[3:0]);

  always_comb begin
    fin_pop = '0;
    if (name_count >= NCW'(NAME_LIMIT)) begin
      fin_status = nnrp_pkg::ST_NAME_LONG;
    end else if (name_count == '0) begin
      fin_status = nnrp_pkg::ST_NAME_EMPTY;
    end else if (digit_count > DCW'(DIGIT_LIMIT)) begin
      fin_status = nnrp_pkg::ST_DIGITS_LONG;
    end else if (digit_count == '0) begin
      fin_status = nnrp_pkg::ST_NO_DIGITS;
    end else if (bad_digit_seen) begin
      fin_status = nnrp_pkg::ST_NON_DIGIT;
    end else if (value_acc == '0) begin
      fin_status = nnrp_pkg::ST_ZERO;
    end else begin
      fin_status = nnrp_pkg::ST_OK;
      fin_pop    = value_acc;
    end
  end

  always_comb begin
    phase_next          = phase;
    name_count_next     = name_count;
    digit_count_next    = digit_count;
    value_acc_next      = value_acc;
    overflowed_next     = overflowed;
    bad_digit_seen_next = bad_digit_seen;
    res_valid           = 1'b0;
    res_name            = 1'b0;
    res_done            = 1'b0;
    res_status          = nnrp_pkg::ST_OK;
    res_pop             = '0;

    if (item.line_end) begin
      unique case (phase)
        nnrp_pkg::PH_NAME: begin
          res_valid  = 1'b1;
          res_done   = 1'b1;
          res_status = nnrp_pkg::ST_NO_COMMA;
        end
        nnrp_pkg::PH_NUM: begin
          res_valid  = 1'b1;
          res_done   = 1'b1;
          res_status = fin_status;
          res_pop    = fin_pop;
        end
        default: begin
        end
      endcase
      phase_next          = nnrp_pkg::PH_NAME;
      name_count_next     = '0;
      digit_count_next    = '0;
      value_acc_next      = '0;
      overflowed_next     = 1'b0;
      bad_digit_seen_next = 1'b0;
    end else begin
      unique case (phase)
        nnrp_pkg::PH_NAME: begin
          if (item.char_code == nnrp_pkg::CH_NEWLINE) begin
            res_valid  = 1'b1;
            res_done   = 1'b1;
            res_status = nnrp_pkg::ST_NO_COMMA;
            phase_next = nnrp_pkg::PH_DRAIN;
          end else if (item.char_code == nnrp_pkg::CH_COMMA) begin
            phase_next = nnrp_pkg::PH_NUM;
          end else if (name_count < NCW'(NAME_LIMIT)) begin
            res_valid       = 1'b1;
            res_name        = 1'b1;
            name_count_next = name_count + 1'b1;
          end
        end
        nnrp_pkg::PH_NUM: begin
          if (item.char_code == nnrp_pkg::CH_NEWLINE) begin
            res_valid  = 1'b1;
            res_done   = 1'b1;
            res_status = fin_status;
            res_pop    = fin_pop;
            phase_next = nnrp_pkg::PH_DRAIN;
          end else begin
            if (digit_count <= DCW'(DIGIT_LIMIT)) begin
              digit_count_next = digit_count + 1'b1;
            end
            if (is_digit) begin
              if (!bad_digit_seen && !overflowed) begin
                if (acc_sum[SW-1:PW] != '0) begin
                  overflowed_next = 1'b1;
                  value_acc_next  = '1;
                end else begin
                  value_acc_next = acc_sum[PW-1:0];
                end
              end
            end else begin
              bad_digit_seen_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_free  = !rec_out.valid || rec_out.ready;
  assign fire      = item_valid && (!res_valid || out_free);
  assign item_take = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= nnrp_pkg::PH_NAME;
      name_count     <= '0;
      digit_count    <= '0;
      value_acc      <= '0;
      overflowed     <= 1'b0;
      bad_digit_seen <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      name_count     <= name_count_next;
      digit_count    <= digit_count_next;
      value_acc      <= value_acc_next;
      overflowed     <= overflowed_next;
      bad_digit_seen <= bad_digit_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out.valid <= 1'b0;
    end else if (fire && res_valid) begin
      rec_out.valid <= 1'b1;
    end else if (rec_out.ready) begin
      rec_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      rec_out.is_name_byte <= res_name;
      rec_out.name_byte    <= res_name ? item.char_code : '0;
      rec_out.name_index   <= res_name ? count_ext[nnrp_pkg::INDEX_W-1:0] : '0;
      rec_out.record_done  <= res_done;
      rec_out.status       <= res_status;
      rec_out.population   <= res_pop;
      rec_out.name_length  <= res_done ? count_ext[nnrp_pkg::LEN_W-1:0] : '0;
    end
  end

endmodule

[rtl/nnrp_checker.sv]
// Port-level assertions for the record parser result channel, bound to the top level.
// Depends on nnrp_pkg and name_number_record_parser.
module nnrp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         is_name_byte,
  input logic [nnrp_pkg::CHAR_W-1:0]  name_byte,
  input logic [nnrp_pkg::INDEX_W-1:0] name_index,
  input logic                         record_done,
  input logic [2:0]                   status,
  input logic [nnrp_pkg::POP_W-1:0]   population,
  input logic [nnrp_pkg::LEN_W-1:0]   name_length
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({is_name_byte, name_byte, name_index, record_done, status, population,
               name_length}))
    else $error("stalled result changed");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_name_byte != record_done))
    else $error("result is neither or both of name byte and record end");

  a_name_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_name_byte |->
      status == nnrp_pkg::ST_OK && population == '0 && name_length == '0)
    else $error("name byte result carries record fields");

  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_done |-> ((status == nnrp_pkg::ST_OK) == (population != '0)))
    else $error("population disagrees with status");

endmodule

bind name_number_record_parser nnrp_checker u_nnrp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (rec_out.valid),
  .out_ready    (rec_out.ready),
  .is_name_byte (rec_out.is_name_byte),
  .name_byte    (rec_out.name_byte),
  .name_index   (rec_out.name_index),
  .record_done  (rec_out.record_done),
  .status       (rec_out.status),
  .population   (rec_out.population),
  .name_length  (rec_out.name_length)
);
